[rtl/h264fs_pkg.sv]
// shared types, constants and helpers of the annex b frame splitter
`timescale 1ns / 1ps
`default_nettype none

package h264fs_pkg;

    // longest frame or raw chunk in bytes
    localparam int unsigned MAX_FRAME_BYTES = 65536;
    // byte counter holds 0 .. MAX_FRAME_BYTES
    localparam int unsigned CNT_W           = $clog2(MAX_FRAME_BYTES + 1);
    localparam int unsigned LEN_W           = 17;
    localparam int unsigned IDR_W           = 32;
    localparam int unsigned SKIP_W          = 4;

    localparam int unsigned WIN_DEPTH       = 9;
    localparam int unsigned WIN_IDX_W       = $clog2(WIN_DEPTH);
    localparam int unsigned SKIP_CANDIDATES = 7;
    // bytes held back in the look-ahead window
    localparam int unsigned WIN_TAIL        = WIN_DEPTH - 1;

    // result queue
    localparam int unsigned QUEUE_DEPTH     = 4;
    localparam int unsigned QPTR_W          = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W          = $clog2(QUEUE_DEPTH + 1);

    // nal unit types
    localparam logic [4:0] NAL_SLICE     = 5'd1;
    localparam logic [4:0] NAL_IDR       = 5'd5;
    localparam logic [4:0] NAL_SEI       = 5'd6;
    localparam logic [4:0] NAL_SPS       = 5'd7;
    localparam logic [4:0] NAL_PPS       = 5'd8;
    localparam logic [4:0] NAL_SUBSET_SPS = 5'd15;
    localparam logic [4:0] NAL_SLICE_EXT = 5'd20;
    localparam logic [7:0] NAL_TYPE_MASK = 8'h1F;

    typedef enum logic [1:0] {
        PH_SEEK = 2'd0,
        PH_SKIP = 2'd1,
        PH_END  = 2'd2
    } phase_t;

    typedef struct packed {
        logic [LEN_W-1:0] frame_length;
        logic             start_found;
        logic             idr_start;
        logic [IDR_W-1:0] idr_count;
        logic             hit_limit;
        logic             stream_done;
    } result_t;

    function automatic result_t make_result(
        input logic [CNT_W-1:0] len,
        input logic             sf,
        input logic             idr,
        input logic [IDR_W-1:0] total,
        input logic             lim,
        input logic             done
    );
        result_t r;
        r.frame_length = LEN_W'(len);
        r.start_found  = sf;
        r.idr_start    = idr;
        r.idr_count    = total;
        r.hit_limit    = lim;
        r.stream_done  = done;
        return r;
    endfunction

endpackage

`default_nettype wire

[rtl/h264_annexb_frame_splitter_core.sv]
// annex b byte stream splitter: frame boundaries, lengths and idr count
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-------------------------------------
//  in      | sink      | in_valid / in_stall    | data_byte, end_of_stream
//  out     | source    | out_valid / out_stall  | frame_length, start_found, idr_start,
//          |           |                        | idr_count, hit_limit, stream_done
//  cfg     | sink      | cfg_valid / cfg_ready  | frame_mode
//
// one byte is taken per cycle while in_stall is low; a byte waits in the input register and its
// results are written into the result queue when it is processed
// each byte gives at most two results; the byte in the input register is processed
// only when the four-entry result queue has two free slots, else in_stall is raised
// with out_stall low the queue drains one result per cycle and the input never stalls
// reset clears the window, counters and queue and sets frame_mode to 1
`timescale 1ns / 1ps
`default_nettype none

module h264_annexb_frame_splitter_core (
    input  wire logic                          clk,
    input  wire logic                          rst_n,

    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [7:0]                    data_byte,
    input  wire logic                          end_of_stream,

    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [h264fs_pkg::LEN_W-1:0]       frame_length,
    output logic                               start_found,
    output logic                               idr_start,
    output logic [h264fs_pkg::IDR_W-1:0]       idr_count,
    output logic                               hit_limit,
    output logic                               stream_done,

    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic                          frame_mode
);

    localparam logic [h264fs_pkg::CNT_W-1:0] MAX_CNT =
        h264fs_pkg::CNT_W'(h264fs_pkg::MAX_FRAME_BYTES);
    localparam logic [h264fs_pkg::CNT_W-1:0] WIN_CNT =
        h264fs_pkg::CNT_W'(h264fs_pkg::WIN_DEPTH);
    localparam logic [h264fs_pkg::CNT_W-1:0] TAIL_CNT =
        h264fs_pkg::CNT_W'(h264fs_pkg::WIN_TAIL);
    localparam logic [h264fs_pkg::QCNT_W-1:0] ROOM_LIMIT =
        h264fs_pkg::QCNT_W'(h264fs_pkg::QUEUE_DEPTH - 2);

    // configuration
    logic mode_reg;

    // input register
    logic       in_full_reg;
    logic       in_full_next;
    logic [7:0] byte_reg;
    logic       eos_reg;

    // scan state
    logic [7:0]                       win_reg   [h264fs_pkg::WIN_DEPTH];
    logic [7:0]                       win_next  [h264fs_pkg::WIN_DEPTH];
    logic [h264fs_pkg::CNT_W-1:0]     cnt_reg;
    logic [h264fs_pkg::CNT_W-1:0]     cnt_next;
    h264fs_pkg::phase_t               phase_reg;
    h264fs_pkg::phase_t               phase_next;
    logic [h264fs_pkg::SKIP_W-1:0]    skip_reg;
    logic [h264fs_pkg::SKIP_W-1:0]    skip_next;
    logic                             idr_reg;
    logic                             idr_next;
    logic [h264fs_pkg::IDR_W-1:0]     total_reg;
    logic [h264fs_pkg::IDR_W-1:0]     total_next;

    // result queue
    h264fs_pkg::result_t              queue_reg [h264fs_pkg::QUEUE_DEPTH];
    logic [h264fs_pkg::QPTR_W-1:0]    wr_ptr_reg;
    logic [h264fs_pkg::QPTR_W-1:0]    rd_ptr_reg;
    logic [h264fs_pkg::QCNT_W-1:0]    qcnt_reg;
    logic [h264fs_pkg::QCNT_W-1:0]    qcnt_next;

    // per-byte results
    h264fs_pkg::result_t              res_a;
    h264fs_pkg::result_t              res_b;
    logic [1:0]                       n_res;

    // window decode
    logic       prefix;
    logic [4:0] nal_t;
    logic       slice;
    logic       end_mark;

    logic process;
    logic accept;
    logic pop;

    h264fs_pkg::result_t head;

    // ------------------------------------------------------------------
    // handshakes
    // ------------------------------------------------------------------
    // the byte in the input register moves on only when two queue slots are free
    assign process   = in_full_reg && (qcnt_reg <= ROOM_LIMIT);
    assign in_stall  = in_full_reg && !process;
    assign accept    = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    assign out_valid = (qcnt_reg != '0);
    assign pop       = out_valid && !out_stall;

    assign head         = queue_reg[rd_ptr_reg];
    assign frame_length = head.frame_length;
    assign start_found  = head.start_found;
    assign idr_start    = head.idr_start;
    assign idr_count    = head.idr_count;
    assign hit_limit    = head.hit_limit;
    assign stream_done  = head.stream_done;

    always_comb
    begin
        if (accept)
        begin
            in_full_next = 1'b1;
        end
        else if (process)
        begin
            in_full_next = 1'b0;
        end
        else
        begin
            in_full_next = in_full_reg;
        end
    end

    // ------------------------------------------------------------------
    // window shift and start code decode
    // ------------------------------------------------------------------
    always_comb
    begin
        for (int i = 0; i < h264fs_pkg::WIN_DEPTH - 1; i++)
        begin
            win_next[i] = win_reg[i + 1];
        end
        win_next[h264fs_pkg::WIN_DEPTH - 1] = byte_reg;
    end

    // 00 00 01 followed by the nal header in byte three
    assign prefix = (win_next[0] == 8'h00) && (win_next[1] == 8'h00) && (win_next[2] == 8'h01);
    assign nal_t  = 5'(win_next[3] & h264fs_pkg::NAL_TYPE_MASK);
    // slice start: first_mb flag in byte four, or in byte seven for the extension header
    assign slice  = prefix &&
                    ((((nal_t == h264fs_pkg::NAL_IDR) || (nal_t == h264fs_pkg::NAL_SLICE)) &&
                      win_next[4][7]) ||
                     ((nal_t == h264fs_pkg::NAL_SLICE_EXT) && win_next[7][7]));
    // parameter sets and sei also close a frame
    assign end_mark = slice ||
                      (prefix && ((nal_t == h264fs_pkg::NAL_SUBSET_SPS) ||
                                  (nal_t == h264fs_pkg::NAL_SPS) ||
                                  (nal_t == h264fs_pkg::NAL_PPS) ||
                                  (nal_t == h264fs_pkg::NAL_SEI)));

    // ------------------------------------------------------------------
    // scan step for one byte
    // ------------------------------------------------------------------
    always_comb
    begin
        cnt_next   = (cnt_reg < MAX_CNT) ? cnt_reg + 1'b1 : cnt_reg;
        phase_next = phase_reg;
        skip_next  = skip_reg;
        idr_next   = idr_reg;
        total_next = total_reg;
        res_a      = '0;
        res_b      = '0;
        n_res      = 2'd0;

        if (!mode_reg)
        begin
            // raw chunks
            if (cnt_next >= MAX_CNT)
            begin
                res_a      = h264fs_pkg::make_result(cnt_next, 1'b0, 1'b0, total_next,
                                                     1'b0, 1'b0);
                n_res      = 2'd1;
                cnt_next   = '0;
                phase_next = h264fs_pkg::PH_SEEK;
                skip_next  = '0;
                idr_next   = 1'b0;
            end
        end
        else
        begin
            if (cnt_next >= WIN_CNT)
            begin
                unique case (phase_reg)
                    h264fs_pkg::PH_SEEK:
                    begin
                        if (slice)
                        begin
                            phase_next = h264fs_pkg::PH_SKIP;
                            skip_next  = h264fs_pkg::SKIP_W'(h264fs_pkg::SKIP_CANDIDATES);
                            idr_next   = (nal_t == h264fs_pkg::NAL_IDR);
                            total_next = total_reg + h264fs_pkg::IDR_W'(nal_t == h264fs_pkg::NAL_IDR);
                        end
                    end
                    h264fs_pkg::PH_SKIP:
                    begin
                        if (skip_reg != '0)
                        begin
                            skip_next = skip_reg - 1'b1;
                        end
                        if (skip_next == '0)
                        begin
                            phase_next = h264fs_pkg::PH_END;
                        end
                    end
                    h264fs_pkg::PH_END:
                    begin
                        if (end_mark)
                        begin
                            // boundary: window bytes begin the next frame
                            res_a    = h264fs_pkg::make_result(cnt_next - WIN_CNT, 1'b1, idr_reg,
                                                               total_reg, 1'b0, 1'b0);
                            n_res    = 2'd1;
                            cnt_next = WIN_CNT;
                            if (slice)
                            begin
                                phase_next = h264fs_pkg::PH_SKIP;
                                skip_next  = h264fs_pkg::SKIP_W'(h264fs_pkg::SKIP_CANDIDATES);
                                idr_next   = (nal_t == h264fs_pkg::NAL_IDR);
                                total_next = total_reg +
                                             h264fs_pkg::IDR_W'(nal_t == h264fs_pkg::NAL_IDR);
                            end
                            else
                            begin
                                phase_next = h264fs_pkg::PH_SEEK;
                                skip_next  = '0;
                                idr_next   = 1'b0;
                            end
                        end
                    end
                    default:
                    begin
                        phase_next = h264fs_pkg::PH_SEEK;
                    end
                endcase
            end

            // buffer limit cut
            if (cnt_next >= MAX_CNT)
            begin
                if (phase_next == h264fs_pkg::PH_SEEK)
                begin
                    // keep the window tail as the head of the next frame
                    res_b    = h264fs_pkg::make_result(MAX_CNT - TAIL_CNT, 1'b0, 1'b0,
                                                       total_next, 1'b1, 1'b0);
                    cnt_next = TAIL_CNT;
                end
                else
                begin
                    res_b    = h264fs_pkg::make_result(MAX_CNT, 1'b1, idr_next,
                                                       total_next, 1'b1, 1'b0);
                    cnt_next = '0;
                end
                if (n_res == 2'd0)
                begin
                    res_a = res_b;
                end
                n_res      = n_res + 1'b1;
                phase_next = h264fs_pkg::PH_SEEK;
                skip_next  = '0;
                idr_next   = 1'b0;
            end
        end

        // end of stream flush
        if (eos_reg)
        begin
            if (cnt_next != '0)
            begin
                res_b = h264fs_pkg::make_result(cnt_next,
                                                mode_reg && (phase_next != h264fs_pkg::PH_SEEK),
                                                mode_reg && idr_next, total_next, 1'b0, 1'b1);
                if (n_res == 2'd0)
                begin
                    res_a = res_b;
                end
                n_res = n_res + 1'b1;
            end
            else if (n_res == 2'd1)
            begin
                res_a.stream_done = 1'b1;
            end
            else if (n_res == 2'd2)
            begin
                res_b.stream_done = 1'b1;
            end
            cnt_next   = '0;
            phase_next = h264fs_pkg::PH_SEEK;
            skip_next  = '0;
            idr_next   = 1'b0;
        end
    end

    always_comb
    begin
        qcnt_next = qcnt_reg;
        if (process)
        begin
            qcnt_next = qcnt_next + h264fs_pkg::QCNT_W'(n_res);
        end
        if (pop)
        begin
            qcnt_next = qcnt_next - 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= 1'b1;
            in_full_reg <= 1'b0;
            cnt_reg     <= '0;
            phase_reg   <= h264fs_pkg::PH_SEEK;
            skip_reg    <= '0;
            idr_reg     <= 1'b0;
            total_reg   <= '0;
            wr_ptr_reg  <= '0;
            rd_ptr_reg  <= '0;
            qcnt_reg    <= '0;
            for (int i = 0; i < h264fs_pkg::WIN_DEPTH; i++)
            begin
                win_reg[i] <= 8'h00;
            end
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                mode_reg <= frame_mode;
            end
            in_full_reg <= in_full_next;
            qcnt_reg    <= qcnt_next;
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (process)
            begin
                cnt_reg    <= cnt_next;
                phase_reg  <= phase_next;
                skip_reg   <= skip_next;
                idr_reg    <= idr_next;
                total_reg  <= total_next;
                wr_ptr_reg <= wr_ptr_reg + h264fs_pkg::QPTR_W'(n_res);
                for (int i = 0; i < h264fs_pkg::WIN_DEPTH; i++)
                begin
                    win_reg[i] <= win_next[i];
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            byte_reg <= data_byte;
            eos_reg  <= end_of_stream;
        end
        if (process && (n_res != 2'd0))
        begin
            queue_reg[wr_ptr_reg] <= res_a;
        end
        if (process && (n_res == 2'd2))
        begin
            queue_reg[wr_ptr_reg + 1'b1] <= res_b;
        end
    end

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        qcnt_reg <= h264fs_pkg::QCNT_W'(h264fs_pkg::QUEUE_DEPTH))
        else $error("result queue overflow");

    a_skip_live: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == h264fs_pkg::PH_SKIP) |-> (skip_reg != '0))
        else $error("skip phase with no candidates left");

    a_seek_no_idr: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == h264fs_pkg::PH_SEEK) |-> !idr_reg)
        else $error("idr flag set while seeking a start");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= MAX_CNT)
        else $error("frame byte count above limit");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |=> in_full_reg && $stable(byte_reg) && $stable(eos_reg))
        else $error("stalled input byte lost");

endmodule

`default_nettype wire

[tb/tb_top.sv]
// testbench for the annex b frame splitter core, checked against a cycle-free byte predictor
`timescale 1ns / 1ps

module tb_top;

    // margin for results in flight before a register write or the end check
    localparam int unsigned SETTLE_CYCLES = 4;
    localparam int unsigned DRAIN_LIMIT   = 2000;
    localparam int unsigned MAX_REPORTS   = 10;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                             in_valid      = 1'b0;
    logic                             in_stall;
    logic [7:0]                       data_byte     = 8'h00;
    logic                             end_of_stream = 1'b0;

    logic                             out_valid;
    logic                             out_stall     = 1'b0;
    logic [h264fs_pkg::LEN_W-1:0]     frame_length;
    logic                             start_found;
    logic                             idr_start;
    logic [h264fs_pkg::IDR_W-1:0]     idr_count;
    logic                             hit_limit;
    logic                             stream_done;

    logic                             cfg_valid     = 1'b0;
    logic                             cfg_ready;
    logic                             cfg_mode      = 1'b1;

    // idling of both sides, in cycles per hundred
    int unsigned snd_idle_pct = 0;
    int unsigned rcv_idle_pct = 0;

    // long receiver hold-off: tests bump hold_req, the stall process counts it down
    int unsigned hold_len  = 0;
    int unsigned hold_req  = 0;
    int unsigned hold_ack  = 0;
    int unsigned hold_left = 0;

    int unsigned bytes_sent = 0;
    int unsigned mismatches = 0;
    int unsigned missing    = 0;

    // frame results still to come, oldest first
    h264fs_pkg::result_t expected_frames[$];

    // predictor state
    logic [7:0]                       recent_bytes [h264fs_pkg::WIN_DEPTH];
    logic [h264fs_pkg::CNT_W-1:0]     pending_bytes;
    h264fs_pkg::phase_t               scan_state;
    logic [3:0]                       skip_left;
    logic                             frame_idr;
    logic [h264fs_pkg::IDR_W-1:0]     idr_frames;
    logic                             split_frames;

    h264_annexb_frame_splitter_core DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .data_byte     (data_byte),
        .end_of_stream (end_of_stream),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .frame_length  (frame_length),
        .start_found   (start_found),
        .idr_start     (idr_start),
        .idr_count     (idr_count),
        .hit_limit     (hit_limit),
        .stream_done   (stream_done),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .frame_mode    (cfg_mode)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    function automatic void reset_predictor();
        foreach (recent_bytes[i])
            recent_bytes[i] = 8'h00;
        pending_bytes = '0;
        scan_state    = h264fs_pkg::PH_SEEK;
        skip_left     = '0;
        frame_idr     = 1'b0;
        idr_frames    = '0;
        split_frames  = 1'b1;
    endfunction

    function automatic logic start_code_here();
        return recent_bytes[0] == 8'h00 && recent_bytes[1] == 8'h00 && recent_bytes[2] == 8'h01;
    endfunction

    function automatic logic [4:0] nal_type_here();
        return 5'(recent_bytes[3] & h264fs_pkg::NAL_TYPE_MASK);
    endfunction

    // slice start: type 1 or 5 with first_mb flag, or extension slice with its flag 4 bytes on
    function automatic logic slice_start_here();
        logic [4:0] t;
        t = nal_type_here();
        if (!start_code_here())
            return 1'b0;
        if ((t == h264fs_pkg::NAL_IDR || t == h264fs_pkg::NAL_SLICE) && recent_bytes[4][7])
            return 1'b1;
        return t == h264fs_pkg::NAL_SLICE_EXT && recent_bytes[7][7];
    endfunction

    function automatic logic boundary_here();
        logic [4:0] t;
        t = nal_type_here();
        if (slice_start_here())
            return 1'b1;
        return start_code_here() &&
               (t == h264fs_pkg::NAL_SUBSET_SPS || t == h264fs_pkg::NAL_SPS ||
                t == h264fs_pkg::NAL_PPS || t == h264fs_pkg::NAL_SEI);
    endfunction

    function automatic void restart_frame_scan();
        scan_state = h264fs_pkg::PH_SEEK;
        skip_left  = '0;
        frame_idr  = 1'b0;
    endfunction

    function automatic void try_frame_start();
        if (slice_start_here())
        begin
            scan_state = h264fs_pkg::PH_SKIP;
            skip_left  = 4'(h264fs_pkg::SKIP_CANDIDATES);
            frame_idr  = nal_type_here() == h264fs_pkg::NAL_IDR;
            if (frame_idr)
                idr_frames = idr_frames + 1'b1;
        end
    endfunction

    function automatic void push_frame(input logic [h264fs_pkg::CNT_W-1:0] len, input logic sf,
                                       input logic idr, input logic lim);
        h264fs_pkg::result_t r;
        r.frame_length = h264fs_pkg::LEN_W'(len);
        r.start_found  = sf;
        r.idr_start    = idr;
        r.idr_count    = idr_frames;
        r.hit_limit    = lim;
        r.stream_done  = 1'b0;
        expected_frames.push_back(r);
    endfunction

    // works out the frame results of one accepted byte
    function automatic void predict_frames(input logic [7:0] b, input logic eos);
        int unsigned         emitted;
        h264fs_pkg::result_t last;
        emitted = 0;
        for (int i = 0; i < h264fs_pkg::WIN_DEPTH - 1; i++)
            recent_bytes[i] = recent_bytes[i + 1];
        recent_bytes[h264fs_pkg::WIN_DEPTH - 1] = b;
        if (pending_bytes < h264fs_pkg::MAX_FRAME_BYTES)
            pending_bytes++;

        if (!split_frames)
        begin
            // raw chunks of the full limit
            if (pending_bytes >= h264fs_pkg::MAX_FRAME_BYTES)
            begin
                push_frame(pending_bytes, 1'b0, 1'b0, 1'b0);
                emitted++;
                pending_bytes = '0;
                restart_frame_scan();
            end
        end
        else
        begin
            if (pending_bytes >= h264fs_pkg::WIN_DEPTH)
            begin
                case (scan_state)
                    h264fs_pkg::PH_SEEK:
                        try_frame_start();
                    h264fs_pkg::PH_SKIP:
                    begin
                        if (skip_left > 0)
                            skip_left--;
                        if (skip_left == 0)
                            scan_state = h264fs_pkg::PH_END;
                    end
                    h264fs_pkg::PH_END:
                    begin
                        if (boundary_here())
                        begin
                            // the window bytes open the next frame, checked at once
                            push_frame(pending_bytes -
                                       h264fs_pkg::CNT_W'(h264fs_pkg::WIN_DEPTH),
                                       1'b1, frame_idr, 1'b0);
                            emitted++;
                            pending_bytes = h264fs_pkg::CNT_W'(h264fs_pkg::WIN_DEPTH);
                            restart_frame_scan();
                            try_frame_start();
                        end
                    end
                    default:
                        ;
                endcase
            end
            if (pending_bytes >= h264fs_pkg::MAX_FRAME_BYTES)
            begin
                if (scan_state == h264fs_pkg::PH_SEEK)
                begin
                    // no start yet: the window tail carries over
                    push_frame(h264fs_pkg::CNT_W'(h264fs_pkg::MAX_FRAME_BYTES -
                                                  h264fs_pkg::WIN_TAIL),
                               1'b0, 1'b0, 1'b1);
                    pending_bytes = h264fs_pkg::CNT_W'(h264fs_pkg::WIN_TAIL);
                end
                else
                begin
                    push_frame(h264fs_pkg::CNT_W'(h264fs_pkg::MAX_FRAME_BYTES), 1'b1,
                               frame_idr, 1'b1);
                    pending_bytes = '0;
                end
                emitted++;
                restart_frame_scan();
            end
        end

        if (eos)
        begin
            if (pending_bytes > 0)
            begin
                push_frame(pending_bytes, split_frames && scan_state != h264fs_pkg::PH_SEEK,
                           split_frames && frame_idr, 1'b0);
                emitted++;
            end
            if (emitted > 0)
            begin
                last = expected_frames.pop_back();
                last.stream_done = 1'b1;
                expected_frames.push_back(last);
            end
            pending_bytes = '0;
            restart_frame_scan();
        end
    endfunction

    // ------------------------------------------------------------------
    // receiver: random stall or a counted hold-off
    // ------------------------------------------------------------------

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            hold_ack  <= 0;
            hold_left <= 0;
        end
        else if (hold_req != hold_ack)
        begin
            hold_ack  <= hold_req;
            hold_left <= hold_len;
            out_stall <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= $urandom_range(99) < rcv_idle_pct;
    end

    // result check: every transfer against the oldest expectation
    always @(posedge clk)
    begin : check_frames
        h264fs_pkg::result_t got;
        h264fs_pkg::result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got.frame_length = frame_length;
            got.start_found  = start_found;
            got.idr_start    = idr_start;
            got.idr_count    = idr_count;
            got.hit_limit    = hit_limit;
            got.stream_done  = stream_done;
            if (expected_frames.size() == 0)
            begin
                if (mismatches < MAX_REPORTS)
                    $display("unexpected frame result: len %0d sf %0b idr %0b",
                             got.frame_length, got.start_found, got.idr_start,
                             " cnt %0d lim %0b done %0b",
                             got.idr_count, got.hit_limit, got.stream_done);
                mismatches++;
            end
            else
            begin
                want = expected_frames.pop_front();
                if (got !== want)
                begin
                    if (mismatches < MAX_REPORTS)
                        $display("frame result mismatch at %0t: expected len %0d sf %0b",
                                 $time, want.frame_length, want.start_found,
                                 " idr %0b cnt %0d lim %0b done %0b,",
                                 want.idr_start, want.idr_count, want.hit_limit,
                                 want.stream_done,
                                 " got len %0d sf %0b idr %0b cnt %0d lim %0b done %0b",
                                 got.frame_length, got.start_found, got.idr_start,
                                 got.idr_count, got.hit_limit, got.stream_done);
                    mismatches++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // sender helpers
    // ------------------------------------------------------------------

    // one byte transfer; valid stays up between back-to-back bytes
    task automatic send_byte(input logic [7:0] b, input logic eos);
        while ($urandom_range(99) < snd_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        data_byte     <= b;
        end_of_stream <= eos;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_frames(b, eos);
        bytes_sent++;
    endtask

    function automatic logic [7:0] nal_header(input logic [4:0] t);
        logic [7:0] h;
        h      = 8'($urandom_range(255));
        h[4:0] = t;
        return h;
    endfunction

    // start code, header and random body; marked sets the slice flag bit where it lives
    task automatic send_nal(input logic [7:0] header, input int unsigned body_len,
                            input logic marked, input logic long_code);
        logic [7:0] b;
        if (long_code)
            send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(header, 1'b0);
        for (int unsigned i = 0; i < body_len; i++)
        begin
            b = 8'($urandom_range(255));
            if ((header[4:0] == h264fs_pkg::NAL_SLICE_EXT) ? (i == 3) : (i == 0))
                b[7] = marked;
            send_byte(b, 1'b0);
        end
    endtask

    task automatic close_stream();
        send_byte(8'($urandom_range(255)), 1'b1);
    endtask

    task automatic set_idling(input int unsigned snd_pct, input int unsigned rcv_pct);
        snd_idle_pct = snd_pct;
        rcv_idle_pct = rcv_pct;
    endtask

    // sender off, every expected result in, then the latency settles
    task automatic wait_block_idle();
        in_valid <= 1'b0;
        while (expected_frames.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    task automatic write_frame_mode(input logic mode);
        wait_block_idle();
        cfg_valid <= 1'b1;
        cfg_mode  <= mode;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid    <= 1'b0;
        split_frames = mode;
    endtask

    // a mix of well-formed access units with random content, plus noise and broken codes
    task automatic send_random_nal();
        int unsigned pick;
        int unsigned body;
        logic [4:0]  t;
        pick = $urandom_range(99);
        body = ($urandom_range(9) == 0) ? $urandom_range(25, 70) : $urandom_range(1, 24);
        if (pick < 45)
        begin
            t = ($urandom_range(1) == 0) ? h264fs_pkg::NAL_SLICE : h264fs_pkg::NAL_IDR;
            send_nal(nal_header(t), body, $urandom_range(99) < 90, $urandom_range(3) == 0);
        end
        else if (pick < 55)
            send_nal(nal_header(h264fs_pkg::NAL_SLICE_EXT), body + 3, $urandom_range(99) < 85,
                     $urandom_range(3) == 0);
        else if (pick < 80)
        begin
            case ($urandom_range(3))
                0:       t = h264fs_pkg::NAL_SEI;
                1:       t = h264fs_pkg::NAL_SPS;
                2:       t = h264fs_pkg::NAL_PPS;
                default: t = h264fs_pkg::NAL_SUBSET_SPS;
            endcase
            send_nal(nal_header(t), body, 1'($urandom_range(1)), $urandom_range(3) == 0);
        end
        else if (pick < 88)
            send_nal(nal_header(5'($urandom_range(31))), body, 1'($urandom_range(1)),
                     1'($urandom_range(1)));
        else if (pick < 94)
            repeat ($urandom_range(1, 12))
                send_byte(8'($urandom_range(255)), 1'b0);
        else
        begin
            // start code cut short or bent
            send_byte(8'h00, 1'b0);
            send_byte(8'h00, 1'b0);
            send_byte(($urandom_range(1) == 0) ? 8'h00 : 8'($urandom_range(2, 255)), 1'b0);
        end
        if ($urandom_range(99) < 4)
            close_stream();
    endtask

    task automatic run_random_bytes(input int unsigned count);
        int unsigned goal;
        goal = bytes_sent + count;
        while (bytes_sent < goal)
            send_random_nal();
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // junk ahead of a start, idr start, extension slice as boundary, flush at end of stream
    task automatic test_directed_stream();
        write_frame_mode(1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_nal(8'h65, 5, 1'b1, 1'b0);
        send_nal(8'h74, 5, 1'b1, 1'b0);
        send_nal(8'h06, 0, 1'b0, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b1);
    endtask

    task automatic test_random_streams();
        set_idling(33, 57);
        run_random_bytes(320);
        set_idling(57, 33);
        run_random_bytes(320);
        set_idling(0, 0);
        run_random_bytes(320);
        close_stream();
    endtask

    // receiver holds off while short frames keep coming, so the queue fills and input stalls
    task automatic test_output_backpressure();
        set_idling(0, 0);
        hold_len <= 150;
        hold_req <= hold_req + 1;
        repeat (14)
            send_nal(nal_header(h264fs_pkg::NAL_SLICE), 5, 1'b1, 1'b0);
        close_stream();
        // sender waits for every result before going on
        wait_block_idle();
    endtask

    task automatic test_raw_chunks();
        set_idling(33, 57);
        write_frame_mode(1'b0);
        repeat (300)
            send_byte(8'($urandom_range(255)), $urandom_range(99) < 3);
        close_stream();
        // mode change mid-frame: window and byte count carry on
        set_idling(57, 33);
        send_nal(nal_header(h264fs_pkg::NAL_SLICE), 6, 1'b1, 1'b0);
        write_frame_mode(1'b1);
        send_nal(nal_header(h264fs_pkg::NAL_IDR), 10, 1'b1, 1'b0);
        send_nal(nal_header(h264fs_pkg::NAL_PPS), 4, 1'b0, 1'b1);
        send_nal(nal_header(h264fs_pkg::NAL_IDR), 12, 1'b1, 1'b0);
        write_frame_mode(1'b0);
        repeat (30)
            send_byte(8'($urandom_range(255)), 1'b0);
        close_stream();
        write_frame_mode(1'b1);
        set_idling(0, 0);
        run_random_bytes(100);
        close_stream();
    endtask

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------

    initial
    begin
        reset_predictor();
        repeat (4)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_stream();
        test_random_streams();
        test_output_backpressure();
        test_raw_chunks();

        in_valid <= 1'b0;
        for (int unsigned c = 0; c < DRAIN_LIMIT && expected_frames.size() != 0; c++)
            @(posedge clk);
        repeat (SETTLE_CYCLES * 2)
            @(posedge clk);
        missing = expected_frames.size();
        if (missing != 0)
            $display("%0d frame results never arrived", missing);

        if (mismatches == 0 && missing == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

    // guard against a hung handshake
    initial
    begin
        #200000;
        $display("tb_top failed");
        $finish;
    end

endmodule
